FILE: hw/rtl/ritoa_pkg.sv
// Shared types and constants for the radix integer-to-ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package ritoa_pkg;

  localparam int NUMBER_W    = 64;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 7;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] BASE_MIN    = 5'd2;
  localparam logic [RADIX_W-1:0] BASE_MAX    = 5'd16;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = 7'd55;

  // Commands from the sequencer to the serial divider.
  typedef struct packed {
    logic start_new;
    logic start_next;
  } div_ctrl_t;

  // Divider status; digit and nonzero are meaningful when done is high.
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] digit;
    logic               nonzero;
  } div_status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    return (d < 4'd10) ? (CHAR_ZERO + d_ext) : (CHAR_ALPHA + d_ext);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ritoa_div.sv
// Bit-serial restoring divider by a small base, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ritoa_div #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire ritoa_pkg::div_ctrl_t      ctrl,
  input  wire [VALUE_WIDTH-1:0]          value,
  input  wire [ritoa_pkg::RADIX_W-1:0]   base,
  output ritoa_pkg::div_status_t         status
);
  import ritoa_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] quo;
  logic [DIGIT_W-1:0]     rem;
  logic [CW-1:0]          bit_cnt;
  logic                   busy;
  logic                   done;
  logic                   nz;

  logic [RADIX_W-1:0]     rem_shift;
  logic [RADIX_W-1:0]     rem_diff;
  logic                   ge;

  // The remainder stays below the base, so it fits in four bits.
  assign rem_shift = {rem, quo[VALUE_WIDTH-1]};
  assign ge        = (rem_shift >= base);
  assign rem_diff  = rem_shift - base;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
      nz      <= 1'b0;
      rem     <= '0;
      quo     <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start_new || ctrl.start_next) begin
        if (ctrl.start_new) begin
          quo <= value;
        end
        rem     <= '0;
        nz      <= 1'b0;
        bit_cnt <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        quo     <= {quo[VALUE_WIDTH-2:0], ge};
        rem     <= ge ? rem_diff[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
        nz      <= nz | ge;
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == CW'(VALUE_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.done    = done;
  assign status.digit   = rem;
  assign status.nonzero = nz;

endmodule

`default_nettype wire

FILE: hw/rtl/radix_integer_to_ascii.sv
// Top level of the radix integer-to-ASCII converter.
// Each digit comes from a full division in the serial divider (one quotient
// bit per cycle); the digits are then read from the digit store through the
// output register. A new number is taken only once every digit of the last
// one has been read from the store; the final digit may still wait in the output.
// Reset (rst, synchronous, active high) sets radix to 10 and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module radix_integer_to_ascii #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 64
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [ritoa_pkg::RADIX_W-1:0]  cfg_wdata,
  input  wire                           number_valid,
  output logic                          number_ready,
  input  wire [ritoa_pkg::NUMBER_W-1:0] number,
  output logic                          digit_valid,
  input  wire                           digit_ready,
  output logic [ritoa_pkg::CHAR_W-1:0]  digit_char,
  output logic                          last_digit
);
  import ritoa_pkg::*;

  localparam int AW = $clog2(MAX_DIGITS);

  // Configured base, and the clamped base captured when an item is taken.
  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] base_eff;
  logic [RADIX_W-1:0] base_clamped;

  state_t state;

  // Digit store: remainders land at increasing addresses, least significant
  // digit first, and are read back from the top down.
  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [DIGIT_W-1:0] rd_data;
  logic               rd_last;
  logic               rd_pending;

  div_ctrl_t   div_ctrl;
  div_status_t div_status;

  logic accept;
  logic store_we;
  logic rd_issue;

  assign base_clamped = (radix < BASE_MIN) ? BASE_MIN :
                        (radix > BASE_MAX) ? BASE_MAX : radix;

  assign number_ready = (state == S_IDLE);
  assign accept       = number_valid && number_ready;
  assign store_we     = (state == S_DIV) && div_status.done;

  // A read is started only when the output register will be free by the time
  // the registered store data arrives.
  assign rd_issue = (state == S_EMIT) && !rd_pending && (!digit_valid || digit_ready);

  always_comb begin
    div_ctrl.start_new  = accept;
    div_ctrl.start_next = store_we && div_status.nonzero &&
                          (wr_ptr != AW'(MAX_DIGITS - 1));
  end

  ritoa_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (div_ctrl),
    .value (number[VALUE_WIDTH-1:0]),
    .base  (base_eff),
    .status(div_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  // Sequencer: take an item, collect one digit per division, then read the
  // digits back most significant first. The last read hands control back to
  // idle so the next item can start while that digit waits in the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      base_eff   <= BASE_MIN;
      rd_pending <= 1'b0;
      rd_last    <= 1'b0;
    end else begin
      rd_pending <= rd_issue;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            base_eff <= base_clamped;
            wr_ptr   <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            if (div_ctrl.start_next) begin
              wr_ptr <= wr_ptr + 1'b1;
            end else begin
              rd_ptr <= wr_ptr;
              state  <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (rd_issue) begin
            rd_last <= (rd_ptr == '0);
            if (rd_ptr == '0) begin
              state <= S_IDLE;
            end else begin
              rd_ptr <= rd_ptr - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      digit_store[wr_ptr] <= div_status.digit;
    end
    if (rd_issue) begin
      rd_data <= digit_store[rd_ptr];
    end
  end

  // Output register: loaded from the store read, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (rd_pending) begin
      digit_valid <= 1'b1;
    end else if (digit_ready) begin
      digit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      digit_char <= glyph(rd_data);
      last_digit <= rd_last;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ritoa_check.sv
// Port-level checks for the radix integer-to-ASCII converter, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module ritoa_check (
  input wire                           clk,
  input wire                           rst,
  input wire                           number_valid,
  input wire                           number_ready,
  input wire                           digit_valid,
  input wire                           digit_ready,
  input wire [ritoa_pkg::CHAR_W-1:0]   digit_char,
  input wire                           last_digit
);

  // Reset leaves no item in the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !digit_valid)
    else $error("output item valid after reset");

  // A stalled item holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    digit_valid && !digit_ready |=> digit_valid && $stable(digit_char) && $stable(last_digit))
    else $error("stalled output item changed");

  // An accepted number closes the input behind it.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    number_valid && number_ready |=> !number_ready)
    else $error("input ready right after accepting a number");

  // No new number is taken while a digit other than the final one is in the output.
  a_mid_string: assert property (@(posedge clk) disable iff (rst)
    digit_valid && !last_digit |-> !number_ready)
    else $error("input ready in the middle of a digit string");

  // After the final digit leaves, nothing follows at once.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    digit_valid && digit_ready && last_digit |=> !digit_valid)
    else $error("output item right after the final digit");

endmodule

bind radix_integer_to_ascii ritoa_check u_ritoa_check (.*);

`default_nettype wire
